// ===== rtl/core/rdpp_pkg.sv =====
// Package for the display pixel packer: sizes, codes and shared types.
package rdpp_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam int CHAN_W = 16;
  localparam int SUM_W = 18;
  localparam logic [SUM_W-1:0] BEST_INIT = SUM_W'(3 * 65536);

  typedef enum logic {
    FUNC_WRITE   = 1'b0,
    FUNC_CONVERT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    FMT_PALETTE = 2'd0,
    FMT_RGB555  = 2'd1,
    FMT_RGB565  = 2'd2,
    FMT_DIRECT  = 2'd3
  } fmt_e;

  typedef enum logic [2:0] {
    ORD_RGB = 3'd0,
    ORD_RBG = 3'd1,
    ORD_BRG = 3'd2,
    ORD_BGR = 3'd3,
    ORD_GRB = 3'd4,
    ORD_GBR = 3'd5
  } order_e;

  typedef enum logic [2:0] {
    CFG_PIXEL_FORMAT  = 3'd0,
    CFG_CHANNEL_ORDER = 3'd1,
    CFG_MASK_ENABLE   = 3'd2,
    CFG_MASK_RED      = 3'd3,
    CFG_MASK_GREEN    = 3'd4,
    CFG_MASK_BLUE     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pal_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] index;
  } search_res_t;

endpackage

// ===== rtl/core/rdpp_palette_ram.sv =====
// Generic one-write, one-read synchronous RAM with registered read data.
module rdpp_palette_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 48,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rdpp_search.sv =====
// Nearest palette entry search: sweeps the palette RAM and keeps the best match.
module rdpp_search
  import rdpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output rd_req_t     rd_req_o,
  input  pal_entry_t  rd_data_i,
  output search_res_t res_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  logic             issue_q, rvalid_q, svalid_q, done_q;
  logic             rlast_q, slast_q;
  logic [IDX_W-1:0] addr_q, ridx_q, sidx_q, best_idx_q;
  logic [SUM_W-1:0] sum_q, best_sum_q, sum_d;
  logic [7:0]       red_q, green_q, blue_q;
  logic [CHAN_W-1:0] dr, dg, db, tr, tg, tb;

  always_comb begin
    tr = {red_q, 8'h00};
    tg = {green_q, 8'h00};
    tb = {blue_q, 8'h00};
    dr = (tr > rd_data_i.red)   ? tr - rd_data_i.red   : rd_data_i.red - tr;
    dg = (tg > rd_data_i.green) ? tg - rd_data_i.green : rd_data_i.green - tg;
    db = (tb > rd_data_i.blue)  ? tb - rd_data_i.blue  : rd_data_i.blue - tb;
    sum_d = SUM_W'(dr) + SUM_W'(dg) + SUM_W'(db);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q  <= 1'b0;
      rvalid_q <= 1'b0;
      svalid_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (start_i) begin
        issue_q <= 1'b1;
      end else if (issue_q && addr_q == LAST_IDX) begin
        issue_q <= 1'b0;
      end
      rvalid_q <= issue_q;
      svalid_q <= rvalid_q;
      done_q   <= svalid_q && slast_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      addr_q     <= '0;
      red_q      <= red_i;
      green_q    <= green_i;
      blue_q     <= blue_i;
      best_sum_q <= BEST_INIT;
      best_idx_q <= '0;
    end else begin
      if (issue_q) begin
        addr_q <= addr_q + 1'b1;
      end
      if (svalid_q && sum_q < best_sum_q) begin
        best_sum_q <= sum_q;
        best_idx_q <= sidx_q;
      end
    end
    ridx_q  <= addr_q;
    rlast_q <= (addr_q == LAST_IDX);
    sum_q   <= sum_d;
    sidx_q  <= ridx_q;
    slast_q <= rlast_q;
  end

  assign rd_req_o.en   = issue_q;
  assign rd_req_o.addr = addr_q;
  assign res_o.done    = done_q;
  assign res_o.index   = best_idx_q;

endmodule

// ===== rtl/core/rgb_to_display_pixel_packer.sv =====
// Top level of the RGB to display pixel packer.
//
// Requests arrive on the s_axis channel. tuser selects the kind: a palette
// write stores pal_red/green/blue at pal_index and gives no result; a
// convert request packs red/green/blue into a display pixel by the
// configured format and gives one result on m_axis (pixel in tdata,
// opaque flag in tuser).
// Direct formats (RGB555, RGB565, 24-bit) have the result in the output
// register on the cycle after acceptance, and a new request may follow
// every cycle while the receiver takes each result. Palette mode sweeps
// the palette RAM one entry per cycle through a read, sum and compare
// pipeline, and no request is taken until its result is registered.
// A request may be accepted in the cycle the previous result is taken; if
// the receiver stalls with a result still pending, input stops.
// Configuration writes take effect at once and must be made while idle.
// Reset clears the configuration to 24-bit RGB, mask off; the palette RAM
// is not cleared and must be written before palette mode is used.
module rgb_to_display_pixel_packer
  import rdpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // red[7:0], green[15:8], blue[23:16], pal_index[31:24],
  // pal_red[47:32], pal_green[63:48], pal_blue[79:64]
  input  logic [79:0] s_axis_tdata,
  // func[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_value[23:0]
  output logic [23:0] m_axis_tdata,
  // opaque[0]
  output logic        m_axis_tuser
);

  logic [1:0] fmt_q;
  logic [2:0] order_q;
  logic       mask_en_q;
  logic [7:0] mask_r_q, mask_g_q, mask_b_q;

  state_e      state_q, state_d;
  logic        m_valid_q, m_valid_d;
  logic [23:0] m_data_q, m_data_d;
  logic        m_opaque_q, m_opaque_d;
  logic        pend_opaque_q, pend_opaque_d;
  logic [IDX_W-1:0] hold_idx_q, hold_idx_d;

  logic [7:0]  in_r, in_g, in_b, in_idx;
  logic        accept, out_free, start, opaque_now;
  logic [23:0] direct_pix, packed_pix;
  logic        ram_we;

  rd_req_t     rd_req;
  pal_entry_t  rd_data, wr_data;
  search_res_t res;

  assign in_r   = s_axis_tdata[7:0];
  assign in_g   = s_axis_tdata[15:8];
  assign in_b   = s_axis_tdata[23:16];
  assign in_idx = s_axis_tdata[31:24];
  assign wr_data.red   = s_axis_tdata[47:32];
  assign wr_data.green = s_axis_tdata[63:48];
  assign wr_data.blue  = s_axis_tdata[79:64];

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ram_we        = accept && (s_axis_tuser == FUNC_WRITE)
                         && (32'(in_idx) < PALETTE_ENTRIES);
  assign start         = accept && (s_axis_tuser == FUNC_CONVERT)
                         && (fmt_q == FMT_PALETTE);
  assign opaque_now    = !(mask_en_q && in_r == mask_r_q && in_g == mask_g_q
                           && in_b == mask_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FMT_DIRECT;
      order_q   <= ORD_RGB;
      mask_en_q <= 1'b0;
      mask_r_q  <= '0;
      mask_g_q  <= '0;
      mask_b_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PIXEL_FORMAT:  fmt_q     <= cfg_wdata_i[1:0];
        CFG_CHANNEL_ORDER: order_q   <= cfg_wdata_i[2:0];
        CFG_MASK_ENABLE:   mask_en_q <= cfg_wdata_i[0];
        CFG_MASK_RED:      mask_r_q  <= cfg_wdata_i;
        CFG_MASK_GREEN:    mask_g_q  <= cfg_wdata_i;
        CFG_MASK_BLUE:     mask_b_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (order_q)
      ORD_RBG: direct_pix = {in_r, in_b, in_g};
      ORD_BRG: direct_pix = {in_b, in_r, in_g};
      ORD_BGR: direct_pix = {in_b, in_g, in_r};
      ORD_GRB: direct_pix = {in_g, in_r, in_b};
      ORD_GBR: direct_pix = {in_g, in_b, in_r};
      default: direct_pix = {in_r, in_g, in_b};
    endcase
    case (fmt_q)
      FMT_RGB555: packed_pix = {9'd0, in_r[7:3], in_g[7:3], in_b[7:3]};
      FMT_RGB565: packed_pix = {8'd0, in_r[7:3], in_g[7:2], in_b[7:3]};
      default:    packed_pix = direct_pix;
    endcase
  end

  rdpp_palette_ram #(
    .DEPTH (PALETTE_ENTRIES),
    .WIDTH ($bits(pal_entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_idx[IDX_W-1:0]),
    .wdata_i (wr_data),
    .re_i    (rd_req.en),
    .raddr_i (rd_req.addr),
    .rdata_o (rd_data)
  );

  rdpp_search u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .red_i     (in_r),
    .green_i   (in_g),
    .blue_i    (in_b),
    .rd_req_o  (rd_req),
    .rd_data_i (rd_data),
    .res_o     (res)
  );

  always_comb begin
    state_d       = state_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_data_d      = m_data_q;
    m_opaque_d    = m_opaque_q;
    pend_opaque_d = pend_opaque_q;
    hold_idx_d    = hold_idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && s_axis_tuser == FUNC_CONVERT) begin
          if (fmt_q == FMT_PALETTE) begin
            pend_opaque_d = opaque_now;
            state_d       = ST_SCAN;
          end else begin
            m_valid_d  = 1'b1;
            m_data_d   = packed_pix;
            m_opaque_d = opaque_now;
          end
        end
      end
      ST_SCAN: begin
        if (res.done) begin
          if (out_free) begin
            m_valid_d  = 1'b1;
            m_data_d   = 24'(res.index);
            m_opaque_d = pend_opaque_q;
            state_d    = ST_IDLE;
          end else begin
            hold_idx_d = res.index;
            state_d    = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_data_d   = 24'(hold_idx_q);
          m_opaque_d = pend_opaque_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q      <= m_data_d;
    m_opaque_q    <= m_opaque_d;
    pend_opaque_q <= pend_opaque_d;
    hold_idx_q    <= hold_idx_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_opaque_q;

  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> state_q == ST_SCAN)
    else $error("search finished outside a scan");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_req.en |-> state_q == ST_SCAN)
    else $error("palette read outside a scan");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOLD |-> m_valid_q)
    else $error("result held while output register is empty");

endmodule

// ===== sim/pixel_pack_checker.sv =====
`timescale 1ns / 1ps
// Checker for the display pixel packer: tracks registers and palette, predicts and compares.
module pixel_pack_checker
  import rdpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [79:0] s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int          err_count_o,
  output int          pending_o,
  output int          pixel_count_o,
  output int          search_count_o,
  output int          clear_count_o,
  output int          write_count_o
);

  typedef struct packed {
    logic [23:0] value;
    logic        opaque;
  } disp_pixel_t;

  logic [CHAN_W-1:0] pal_red   [PALETTE_ENTRIES];
  logic [CHAN_W-1:0] pal_green [PALETTE_ENTRIES];
  logic [CHAN_W-1:0] pal_blue  [PALETTE_ENTRIES];

  logic [1:0]  fmt;
  logic [2:0]  order;
  logic        mask_en;
  logic [7:0]  mask_r;
  logic [7:0]  mask_g;
  logic [7:0]  mask_b;

  disp_pixel_t packed_pixels_q[$];

  function automatic int chan_dist(logic [7:0] level, logic [CHAN_W-1:0] entry);
    int d;
    d = int'({level, 8'h00}) - int'(entry);
    return (d < 0) ? -d : d;
  endfunction

  function automatic logic [IDX_W-1:0] nearest_index(logic [7:0] r, logic [7:0] g,
                                                     logic [7:0] b);
    logic [IDX_W-1:0] best;
    int               best_sum;
    int               sum;
    best = '0;
    best_sum = int'(BEST_INIT);
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      sum = chan_dist(r, pal_red[i]) + chan_dist(g, pal_green[i]) + chan_dist(b, pal_blue[i]);
      if (sum < best_sum) begin
        best = IDX_W'(i);
        best_sum = sum;
      end
    end
    return best;
  endfunction

  function automatic disp_pixel_t pack_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    disp_pixel_t px;
    case (fmt)
      FMT_PALETTE: px.value = 24'(nearest_index(r, g, b));
      FMT_RGB555:  px.value = {9'd0, r[7:3], g[7:3], b[7:3]};
      FMT_RGB565:  px.value = {8'd0, r[7:3], g[7:2], b[7:3]};
      default: begin
        case (order)
          ORD_RBG: px.value = {r, b, g};
          ORD_BRG: px.value = {b, r, g};
          ORD_BGR: px.value = {b, g, r};
          ORD_GRB: px.value = {g, r, b};
          ORD_GBR: px.value = {g, b, r};
          default: px.value = {r, g, b};
        endcase
      end
    endcase
    px.opaque = !(mask_en && r == mask_r && g == mask_g && b == mask_b);
    return px;
  endfunction

  initial begin
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      pal_red[i] = '0;
      pal_green[i] = '0;
      pal_blue[i] = '0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    disp_pixel_t got;
    disp_pixel_t want;
    logic [IDX_W-1:0] idx;
    if (!rst_ni) begin
      fmt = FMT_DIRECT;
      order = ORD_RGB;
      mask_en = 1'b0;
      mask_r = '0;
      mask_g = '0;
      mask_b = '0;
      packed_pixels_q.delete();
      err_count_o = 0;
      pending_o = 0;
      pixel_count_o = 0;
      search_count_o = 0;
      clear_count_o = 0;
      write_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_PIXEL_FORMAT:  fmt = cfg_wdata_i[1:0];
          CFG_CHANNEL_ORDER: order = cfg_wdata_i[2:0];
          CFG_MASK_ENABLE:   mask_en = cfg_wdata_i[0];
          CFG_MASK_RED:      mask_r = cfg_wdata_i;
          CFG_MASK_GREEN:    mask_g = cfg_wdata_i;
          CFG_MASK_BLUE:     mask_b = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got.value = m_tdata_i;
        got.opaque = m_tuser_i;
        if (packed_pixels_q.size() == 0) begin
          err_count_o++;
          $display("%0t: unexpected result, got pixel_value %06h opaque %0b",
                   $time, got.value, got.opaque);
        end else begin
          want = packed_pixels_q.pop_front();
          if (got.value !== want.value) begin
            err_count_o++;
            $display("%0t: pixel_value expected %06h, got %06h", $time, want.value, got.value);
          end
          if (got.opaque !== want.opaque) begin
            err_count_o++;
            $display("%0t: opaque expected %0b, got %0b", $time, want.opaque, got.opaque);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == FUNC_WRITE) begin
          idx = s_tdata_i[31:24];
          pal_red[idx] = s_tdata_i[47:32];
          pal_green[idx] = s_tdata_i[63:48];
          pal_blue[idx] = s_tdata_i[79:64];
          write_count_o++;
        end else begin
          want = pack_pixel(s_tdata_i[7:0], s_tdata_i[15:8], s_tdata_i[23:16]);
          packed_pixels_q.push_back(want);
          pixel_count_o++;
          if (fmt == FMT_PALETTE) search_count_o++;
          if (!want.opaque) clear_count_o++;
        end
      end
      pending_o = packed_pixels_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the display pixel packer: clock, reset, stimulus and verdict.
module tb_top;
  import rdpp_pkg::*;

  localparam int RAND_ITEMS = 1100;
  localparam int SETTLE_CYCLES = PALETTE_ENTRIES + 8;
  localparam int LONG_HOLD = 300;
  localparam longint TIMEOUT_NS = 4_000_000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  int err_count, pending, pixel_count, search_count, clear_count, write_count;

  bit         tx_gaps = 1'b1;
  bit         rx_gaps = 1'b1;
  bit         hold_req = 1'b0;
  int         cfg_sets = 0;
  int         rand_items = 0;
  logic [7:0] cur_mask_r = '0;
  logic [7:0] cur_mask_g = '0;
  logic [7:0] cur_mask_b = '0;

  rgb_to_display_pixel_packer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  pixel_pack_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .err_count_o   (err_count),
    .pending_o     (pending),
    .pixel_count_o (pixel_count),
    .search_count_o(search_count),
    .clear_count_o (clear_count),
    .write_count_o (write_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [79:0] pack_request(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                               logic [7:0] idx, logic [15:0] pr,
                                               logic [15:0] pg, logic [15:0] pb);
    return {pb, pg, pr, idx, b, g, r};
  endfunction

  function automatic logic [15:0] rand_level();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return {8'($urandom), 8'h00};
      2: return {8'($urandom), 6'd0, 2'($urandom)};
      default: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hffff;
    endcase
  endfunction

  task automatic push_request(input func_e f, input logic [79:0] d);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= f;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    push_request(FUNC_CONVERT, pack_request(r, g, b, 8'($urandom), 16'($urandom),
                                            16'($urandom), 16'($urandom)));
  endtask

  task automatic send_write(input logic [7:0] idx, input logic [15:0] pr,
                            input logic [15:0] pg, input logic [15:0] pb);
    push_request(FUNC_WRITE, pack_request(8'($urandom), 8'($urandom), 8'($urandom),
                                          idx, pr, pg, pb));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(input fmt_e f, input logic [2:0] o, input logic me,
                             input logic [7:0] mr, input logic [7:0] mg, input logic [7:0] mb);
    drain();
    write_reg(CFG_PIXEL_FORMAT, 8'(f));
    write_reg(CFG_CHANNEL_ORDER, 8'(o));
    write_reg(CFG_MASK_ENABLE, 8'(me));
    write_reg(CFG_MASK_RED, mr);
    write_reg(CFG_MASK_GREEN, mg);
    write_reg(CFG_MASK_BLUE, mb);
    cur_mask_r = mr;
    cur_mask_g = mg;
    cur_mask_b = mb;
    cfg_sets++;
  endtask

  task automatic random_phase(input int n);
    logic [7:0] r, g, b;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_write(8'($urandom), rand_level(), rand_level(), rand_level());
      end else begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          r = cur_mask_r;
          g = cur_mask_g;
          b = cur_mask_b;
          case ($urandom_range(0, 5))
            0: r = r ^ 8'h01;
            1: g = g ^ 8'h80;
            2: b = b ^ 8'h01;
            default: ;
          endcase
        end
        send_pixel(r, g, b);
      end
    end
    rand_items += n;
  endtask

  function automatic logic [7:0] rand_mask_level();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    fmt_e f;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: 24-bit RGB, mask off
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_write(8'h80, 16'h1234, 16'h5678, 16'h9abc);

    // every channel order, including the two undefined codes
    for (int o = 0; o < 8; o++) begin
      load_config(FMT_DIRECT, 3'(o), 1'b0, 8'h00, 8'h00, 8'h00);
      send_pixel(8'ha1, 8'h5c, 8'h3e);
    end

    load_config(FMT_RGB555, ORD_RGB, 1'b0, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h07, 8'h03, 8'h07);
    load_config(FMT_RGB565, ORD_RGB, 1'b1, 8'h12, 8'h34, 8'h56);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h07, 8'h03, 8'h07);
    send_pixel(8'h12, 8'h34, 8'h56);
    send_pixel(8'h12, 8'h34, 8'h57);
    load_config(FMT_DIRECT, ORD_BGR, 1'b1, 8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'hff, 8'hff);
    load_config(FMT_DIRECT, ORD_GBR, 1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00);

    // fill the whole palette before any search
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      if (i == 0) send_write(8'(i), 16'h0000, 16'h0000, 16'h0000);
      else if (i == PALETTE_ENTRIES - 1) send_write(8'(i), 16'hffff, 16'hffff, 16'hffff);
      else send_write(8'(i), rand_level(), rand_level(), rand_level());
    end
    // two equal entries: the lower index must win the tie
    send_write(8'd7, 16'h4000, 16'h8000, 16'hc000);
    send_write(8'd99, 16'h4000, 16'h8000, 16'hc000);
    load_config(FMT_PALETTE, ORD_RGB, 1'b1, 8'h40, 8'h80, 8'hc0);
    send_pixel(8'h40, 8'h80, 8'hc0);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));

    // long receiver hold-off while requests keep coming
    load_config(FMT_RGB565, 3'($urandom_range(0, 7)), 1'($urandom), rand_mask_level(),
                rand_mask_level(), rand_mask_level());
    tx_gaps = 1'b0;
    hold_req = 1'b1;
    random_phase(80);
    tx_gaps = 1'b1;

    while (rand_items < RAND_ITEMS) begin
      f = fmt_e'($urandom_range(0, 3));
      load_config(f, 3'($urandom_range(0, 7)), 1'($urandom), rand_mask_level(),
                  rand_mask_level(), rand_mask_level());
      tx_gaps = ($urandom_range(0, 2) != 0);
      rx_gaps = ($urandom_range(0, 2) != 0);
      random_phase((f == FMT_PALETTE) ? $urandom_range(10, 30) : $urandom_range(60, 160));
    end

    // closing stretch without idling
    load_config(fmt_e'($urandom_range(1, 3)), 3'($urandom_range(0, 7)), 1'b1,
                rand_mask_level(), rand_mask_level(), rand_mask_level());
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    random_phase(60);
    drain();

    $display("Checked %0d pixels (%0d palette searches, %0d transparent), %0d palette writes",
             pixel_count, search_count, clear_count, write_count);
    $display("over %0d register settings with stalls on both channels", cfg_sets);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rdpp_pkg.sv
rtl/core/rdpp_palette_ram.sv
rtl/core/rdpp_search.sv
rtl/core/rgb_to_display_pixel_packer.sv
sim/pixel_pack_checker.sv
sim/tb_top.sv
